/* rtl/core/mplf_pkg.sv */
// ----------------------------------------------------------------------------
// mplf_pkg
// Shared types, constants and helpers for the multi-pattern line filter.
// ----------------------------------------------------------------------------
package mplf_pkg;

  localparam int REQ_W   = 3;
  localparam int BYTE_W  = 8;
  localparam int FIRST_W = 4;

  typedef enum logic [REQ_W-1:0] {
    REQ_PAT_BYTE = 3'd0,
    REQ_PAT_END  = 3'd1,
    REQ_TEXT     = 3'd2,
    REQ_LINE_END = 3'd3,
    REQ_CLEAR    = 3'd4
  } req_e;

  // Control from the sequencer to the match array
  typedef struct packed {
    logic              pat_write;
    logic              pat_commit;
    logic              pat_clear;
    logic              text_step;
    logic              line_clear;
    logic [BYTE_W-1:0] data;
  } mplf_ctrl_t;

  // Space, tab, LF, VT, FF, CR
  function automatic logic is_blank(input logic [BYTE_W-1:0] b);
    logic res;
    res = b inside {8'h20, [8'h09:8'h0D]};
    return res;
  endfunction

endpackage

/* rtl/core/mplf_in_if.sv */
// ----------------------------------------------------------------------------
// mplf_in_if
// Request channel: pattern bytes, text bytes and control requests.
// ----------------------------------------------------------------------------
interface mplf_in_if;
  logic                         valid;
  logic                         ready;
  logic [mplf_pkg::REQ_W-1:0]   req_type;
  logic [mplf_pkg::BYTE_W-1:0]  data_byte;

  modport source (output valid, output req_type, output data_byte, input ready);
  modport sink   (input valid, input req_type, input data_byte, output ready);
endinterface

/* rtl/core/mplf_out_if.sv */
// ----------------------------------------------------------------------------
// mplf_out_if
// Result channel: one line verdict per end of line.
// ----------------------------------------------------------------------------
interface mplf_out_if;
  logic                          valid;
  logic                          ready;
  logic                          line_matched;
  logic [mplf_pkg::FIRST_W-1:0]  first_word;
  logic                          load_overflow;

  modport source (output valid, output line_matched, output first_word,
                  output load_overflow, input ready);
  modport sink   (input valid, input line_matched, input first_word,
                  input load_overflow, output ready);
endinterface

/* rtl/core/mplf_match_array.sv */
// ----------------------------------------------------------------------------
// mplf_match_array
// Pattern byte cells with one shift-and vector per pattern, all patterns
// stepped in parallel on every text byte.
// ----------------------------------------------------------------------------
module mplf_match_array #(
  parameter int NUM_WORDS = 16,
  parameter int WORD_LEN  = 32,
  parameter int WIW       = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1,
  parameter int PIW       = $clog2(WORD_LEN)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  mplf_pkg::mplf_ctrl_t   ctrl,
  input  logic [WIW-1:0]         wr_word,
  input  logic [PIW-1:0]         wr_pos,
  input  logic [PIW-1:0]         last_pos,
  output logic [NUM_WORDS-1:0]   hit_bits
);
  import mplf_pkg::*;

  logic [BYTE_W-1:0]                   store_r [NUM_WORDS][WORD_LEN];
  logic [NUM_WORDS-1:0][WORD_LEN-1:0]  pm_r;
  logic [NUM_WORDS-1:0][WORD_LEN-1:0]  pm_nxt;
  logic [NUM_WORDS-1:0][WORD_LEN-1:0]  end_mask_r;
  logic [NUM_WORDS-1:0]                active_r;
  logic [NUM_WORDS-1:0]                hit_r;
  logic [NUM_WORDS-1:0]                step_hit;
  logic [WORD_LEN-1:0]                 last_onehot;

  // shift-and step: bit p set when bytes 0..p of the pattern end at this byte
  for (genvar w = 0; w < NUM_WORDS; w++) begin : g_word
    for (genvar p = 0; p < WORD_LEN; p++) begin : g_pos
      if (p == 0) begin : g_head
        assign pm_nxt[w][p] = (store_r[w][p] == ctrl.data);
      end else begin : g_tail
        assign pm_nxt[w][p] = pm_r[w][p-1] && (store_r[w][p] == ctrl.data);
      end
    end
    assign step_hit[w] = active_r[w] && |(pm_nxt[w] & end_mask_r[w]);
  end

  always_comb begin
    last_onehot = '0;
    last_onehot[last_pos] = 1'b1;
  end

  // byte cells: no reset, only written positions are ever used
  always_ff @(posedge clk) begin
    for (int w = 0; w < NUM_WORDS; w++) begin
      for (int p = 0; p < WORD_LEN; p++) begin
        if (ctrl.pat_write && wr_word == WIW'(w) && wr_pos == PIW'(p)) begin
          store_r[w][p] <= ctrl.data;
        end
      end
      if (ctrl.pat_commit && wr_word == WIW'(w)) begin
        end_mask_r[w] <= last_onehot;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pm_r     <= '0;
      hit_r    <= '0;
      active_r <= '0;
    end else if (ctrl.pat_clear) begin
      pm_r     <= '0;
      hit_r    <= '0;
      active_r <= '0;
    end else if (ctrl.line_clear) begin
      pm_r  <= '0;
      hit_r <= '0;
    end else if (ctrl.text_step) begin
      pm_r  <= pm_nxt;
      hit_r <= hit_r | step_hit;
    end else if (ctrl.pat_commit) begin
      for (int w = 0; w < NUM_WORDS; w++) begin
        if (wr_word == WIW'(w)) begin
          pm_r[w]     <= '0;
          hit_r[w]    <= 1'b0;
          active_r[w] <= 1'b1;
        end
      end
    end
  end

  assign hit_bits = hit_r;

endmodule

/* rtl/core/mplf_first_hit.sv */
// ----------------------------------------------------------------------------
// mplf_first_hit
// Priority encoder: lowest pattern index with a hit in the finished line.
// ----------------------------------------------------------------------------
module mplf_first_hit #(
  parameter int NUM_WORDS = 16
) (
  input  logic [NUM_WORDS-1:0]          hit_bits,
  output logic                          any_hit,
  output logic [mplf_pkg::FIRST_W-1:0]  first_idx
);
  import mplf_pkg::*;

  always_comb begin
    first_idx = '0;
    for (int w = NUM_WORDS - 1; w >= 0; w--) begin
      if (hit_bits[w]) begin
        first_idx = FIRST_W'(w);
      end
    end
  end

  assign any_hit = |hit_bits;

endmodule

/* rtl/core/multi_pattern_line_filter_unit.sv */
// ----------------------------------------------------------------------------
// multi_pattern_line_filter_unit
// Multi-pattern substring line filter using parallel shift-and matching.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries requests: pattern byte, end of pattern, text byte, end of
//   line, clear patterns. Load patterns first, then stream text; every end
//   of line yields one transaction on out_ch with the line verdict, the
//   lowest matching pattern index and the sticky overflow flag.
//   An accepted request is registered in the input stage and is executed from
//   there; an end of line loads its result into the output register for out_ch.
//   Throughput: one request per cycle unless an end of line waits behind a held
//   result. All patterns step together on each text byte in the match array.
//   Reset (rst_n low, synchronous) empties the pattern list, line progress
//   and the overflow flag; pattern bytes themselves are not cleared.
//   When out_ch stalls, the result holds in the output register; one more
//   request may sit in the input stage, and only an end of line waiting
//   behind the held result stops in_ch.ready.
// ----------------------------------------------------------------------------
module multi_pattern_line_filter_unit #(
  parameter int NUM_WORDS = 16,
  parameter int WORD_LEN  = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  mplf_in_if.sink   in_ch,
  mplf_out_if.source out_ch
);
  import mplf_pkg::*;

  localparam int WTW = $clog2(NUM_WORDS + 1);
  localparam int LPW = $clog2(WORD_LEN + 1);
  localparam int WIW = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int PIW = $clog2(WORD_LEN);

  // input stage
  logic              s1_valid_r;
  logic [REQ_W-1:0]  s1_req_r;
  logic [BYTE_W-1:0] s1_data_r;
  logic              s1_go;
  logic              in_take;

  // loader state
  logic [WTW-1:0]    word_total_r, word_total_nxt;
  logic [LPW-1:0]    load_pos_r, load_pos_nxt;
  logic              ovf_r, ovf_nxt;
  logic              words_full;
  logic              word_full;

  // result register
  logic              out_valid_r;
  logic              out_matched_r;
  logic [FIRST_W-1:0] out_first_r;
  logic              out_ovf_r;
  logic              out_free;
  logic              out_load;

  mplf_ctrl_t        ctrl;
  logic [NUM_WORDS-1:0] hit_bits;
  logic              any_hit;
  logic [FIRST_W-1:0] first_idx;

  assign out_free = !out_valid_r || out_ch.ready;
  assign s1_go    = s1_valid_r && ((s1_req_r != REQ_LINE_END) || out_free);
  assign in_ch.ready = !s1_valid_r || s1_go;
  assign in_take  = in_ch.valid && in_ch.ready;

  assign words_full = word_total_r >= WTW'(NUM_WORDS);
  assign word_full  = load_pos_r >= LPW'(WORD_LEN);

  always_comb begin
    word_total_nxt  = word_total_r;
    load_pos_nxt    = load_pos_r;
    ovf_nxt         = ovf_r;
    out_load        = 1'b0;
    ctrl            = '0;
    ctrl.data       = s1_data_r;
    if (s1_go) begin
      case (s1_req_r)
        REQ_PAT_BYTE: begin
          if (!is_blank(s1_data_r)) begin
            if (words_full || word_full) begin
              ovf_nxt = 1'b1;
            end else begin
              ctrl.pat_write = 1'b1;
              load_pos_nxt   = load_pos_r + LPW'(1);
            end
          end
        end
        REQ_PAT_END: begin
          if (load_pos_r != '0 && !words_full) begin
            ctrl.pat_commit = 1'b1;
            word_total_nxt  = word_total_r + WTW'(1);
          end
          load_pos_nxt = '0;
        end
        REQ_TEXT: begin
          ctrl.text_step = 1'b1;
        end
        REQ_LINE_END: begin
          ctrl.line_clear = 1'b1;
          out_load        = 1'b1;
        end
        REQ_CLEAR: begin
          ctrl.pat_clear = 1'b1;
          word_total_nxt = '0;
          load_pos_nxt   = '0;
          ovf_nxt        = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  mplf_match_array #(
    .NUM_WORDS (NUM_WORDS),
    .WORD_LEN  (WORD_LEN),
    .WIW       (WIW),
    .PIW       (PIW)
  ) u_array (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (ctrl),
    .wr_word  (word_total_r[WIW-1:0]),
    .wr_pos   (load_pos_r[PIW-1:0]),
    .last_pos (PIW'(load_pos_r - LPW'(1))),
    .hit_bits (hit_bits)
  );

  mplf_first_hit #(
    .NUM_WORDS (NUM_WORDS)
  ) u_first (
    .hit_bits  (hit_bits),
    .any_hit   (any_hit),
    .first_idx (first_idx)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      word_total_r <= '0;
      load_pos_r   <= '0;
      ovf_r        <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        s1_valid_r <= in_ch.valid;
      end
      word_total_r <= word_total_nxt;
      load_pos_r   <= load_pos_nxt;
      ovf_r        <= ovf_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_req_r  <= in_ch.req_type;
      s1_data_r <= in_ch.data_byte;
    end
    if (out_load) begin
      out_matched_r <= any_hit;
      out_first_r   <= first_idx;
      out_ovf_r     <= ovf_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.line_matched  = out_matched_r;
  assign out_ch.first_word    = out_first_r;
  assign out_ch.load_overflow = out_ovf_r;

endmodule

/* rtl/core/mplf_checker.sv */
// ----------------------------------------------------------------------------
// mplf_checker
// Port-level checks for the line filter, bound to the top level.
// ----------------------------------------------------------------------------
module mplf_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          line_matched,
  input logic [mplf_pkg::FIRST_W-1:0]  first_word,
  input logic                          load_overflow
);
  import mplf_pkg::*;

  // a result held back by the sink keeps its valid
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out valid dropped while stalled");

  // a held result does not change
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(line_matched) && $stable(first_word)
                                && $stable(load_overflow))
    else $error("out payload changed while stalled");

  // no hit means the index reads zero
  a_no_hit_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !line_matched |-> first_word == '0)
    else $error("first_word nonzero without a match");

  // an empty result register never blocks the request side
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("in ready low with an empty output");

  // reset leaves no result pending
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out valid right after reset");

endmodule

bind multi_pattern_line_filter_unit mplf_checker u_mplf_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .line_matched  (out_ch.line_matched),
  .first_word    (out_ch.first_word),
  .load_overflow (out_ch.load_overflow)
);
